// File: rtl/core/i2cmts_pkg.sv
// Shared types, bus status codes and helpers for the I2C master transfer sequencer.
package i2cmts_pkg;

    // Commands carried on the input channel
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TARGET_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_WRITE_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_READ_LENGTH    = 2'd2;

    // Two-wire master status codes (low three bits masked off)
    localparam logic [7:0] STATUS_MASK    = 8'hF8;
    localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RSTART      = 8'h10;
    localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
    localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
    localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    localparam logic READ_BIT = 1'b1;

    // Completion codes
    localparam logic [1:0] COMP_RUNNING = 2'd0;
    localparam logic [1:0] COMP_SUCCESS = 2'd1;
    localparam logic [1:0] COMP_ERROR   = 2'd2;

    // Sticky error flag bits
    localparam logic [2:0] ERR_NACK     = 3'b001;
    localparam logic [2:0] ERR_ARB_LOST = 3'b010;
    localparam logic [2:0] ERR_BUS      = 3'b100;

    typedef struct packed {
        logic       control_valid;
        logic       send_start;
        logic       send_stop;
        logic       ack_next;
        logic       irq_enable;
        logic       data_out_valid;
        logic [7:0] data_out;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [7:0] rx_index;
        logic [1:0] completion;
        logic [2:0] error_flags;
    } result_t;

    // True when the byte at pos is the final one of a read of len bytes
    function automatic logic is_last_read(input logic [7:0] pos, input logic [7:0] len);
        return (len != 8'd0) && (({1'b0, pos} + 9'd1) == {1'b0, len});
    endfunction

endpackage

// File: rtl/core/i2cmts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module i2cmts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/i2c_master_transfer_sequencer_unit.sv
// I2C master write-then-read transfer sequencer driven by two-wire status codes.
// A result is registered into the output register, or into the skid stage while the output is stalled.
// Throughput: one input transfer per cycle while the skid stage is empty; every command yields exactly one result.
// An output register plus a skid stage keep input accepted while one result is stalled.
// Reset (rst_n low, asynchronous) clears positions, error flags, configuration and both
// output stages; the write store holds no reset value and must be loaded before use.
module i2c_master_transfer_sequencer_unit
    import i2cmts_pkg::*;
#(
    parameter int WRITE_DEPTH = 16
) (
    input  logic       clk,
    input  logic       rst_n,

    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    // input channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] status,
    input  logic [7:0] byte_value,
    input  logic [3:0] load_slot,

    // output channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic       control_valid,
    output logic       send_start,
    output logic       send_stop,
    output logic       ack_next,
    output logic       irq_enable,
    output logic       data_out_valid,
    output logic [7:0] data_out,
    output logic       rx_valid,
    output logic [7:0] rx_byte,
    output logic [7:0] rx_index,
    output logic [1:0] completion,
    output logic [2:0] error_flags
);

    // Store address width, and working widths wide enough to mask or extend into it
    localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam int PW = (AW > 5) ? AW : 5;
    localparam int SW = (AW > 4) ? AW : 4;

    // ------------------------------------------------------------------
    // Configuration registers; the port never stalls
    // ------------------------------------------------------------------
    logic [6:0] target_address_reg;
    logic [4:0] write_length_reg;
    logic [7:0] read_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_address_reg <= '0;
            write_length_reg   <= '0;
            read_length_reg    <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TARGET_ADDRESS: target_address_reg <= cfg_data[6:0];
                CFG_WRITE_LENGTH:   write_length_reg   <= cfg_data[4:0];
                CFG_READ_LENGTH:    read_length_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake state
    // ------------------------------------------------------------------
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    in_fire;
    logic    out_fire;

    // Input stalls only when both the output register and the skid stage are full
    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    logic [4:0] write_position_reg;
    logic [4:0] write_position_next;
    logic [7:0] read_position_reg;
    logic [7:0] read_position_next;
    logic [2:0] error_store_reg;
    logic [2:0] error_store_next;

    logic [4:0] wp_upd;
    logic [7:0] rp_upd;
    logic [2:0] err_upd;
    logic [4:0] eff_write_len;
    logic [7:0] code;
    logic [7:0] rp_inc;
    result_t    res;

    // Write store: loads go straight in; the read side prefetches the entry
    // that the next write position points at, so the byte is ready when the
    // data-ACK status arrives.
    logic          store_we;
    logic [AW-1:0] store_waddr;
    logic [AW-1:0] store_raddr;
    logic [7:0]    store_rdata;
    logic [7:0]    store_data;
    logic [SW-1:0] slot_wide;
    logic [PW-1:0] pos_masked;
    logic          slot_in_range;

    // Bypass for a load that hits the entry being prefetched in the same cycle
    logic       byp_hit_reg;
    logic       byp_hit_next;
    logic [7:0] byp_data_reg;

    assign code    = status & STATUS_MASK;
    assign rp_inc  = read_position_reg + 8'd1;

    // Lengths beyond the store depth clamp to the depth
    assign eff_write_len = ({4'd0, write_length_reg} > 9'(WRITE_DEPTH)) ?
                           5'(WRITE_DEPTH) : write_length_reg;

    assign slot_in_range = ({5'd0, load_slot} < 9'(WRITE_DEPTH));
    assign slot_wide     = SW'(load_slot);
    assign store_we      = in_fire && (command == CMD_LOAD) && slot_in_range;
    assign store_waddr   = slot_wide[AW-1:0];

    // Index by position masked with depth-1
    assign pos_masked    = PW'(write_position_next) & PW'(WRITE_DEPTH - 1);
    assign store_raddr   = pos_masked[AW-1:0];

    assign byp_hit_next  = store_we && (store_waddr == store_raddr);
    assign store_data    = byp_hit_reg ? byp_data_reg : store_rdata;

    i2cmts_ram #(
        .WIDTH (8),
        .DEPTH (WRITE_DEPTH)
    ) u_write_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (store_waddr),
        .wdata (byte_value),
        .raddr (store_raddr),
        .rdata (store_rdata)
    );

    // ------------------------------------------------------------------
    // Decode one command into a result and the state updates
    // ------------------------------------------------------------------
    always_comb
    begin
        res     = '0;
        wp_upd  = write_position_reg;
        rp_upd  = read_position_reg;
        err_upd = error_store_reg;

        unique case (command)
            CMD_BEGIN:
            begin
                // Clear positions and errors, request START
                wp_upd             = '0;
                rp_upd             = '0;
                err_upd            = '0;
                res.control_valid  = 1'b1;
                res.send_start     = 1'b1;
                res.irq_enable     = 1'b1;
            end
            CMD_EVENT:
            begin
                case (code) inside
                    ST_START, ST_RSTART:
                    begin
                        // Address phase: read bit once all write bytes are out
                        res.control_valid  = 1'b1;
                        res.irq_enable     = 1'b1;
                        res.data_out_valid = 1'b1;
                        res.data_out       = {target_address_reg,
                                              ((eff_write_len == 5'd0) ||
                                               (write_position_reg == eff_write_len)) ?
                                              READ_BIT : 1'b0};
                    end
                    ST_SLA_W_ACK, ST_DATA_W_ACK:
                    begin
                        res.control_valid = 1'b1;
                        if (write_position_reg < eff_write_len)
                        begin
                            res.irq_enable     = 1'b1;
                            res.data_out_valid = 1'b1;
                            res.data_out       = store_data;
                            wp_upd             = write_position_reg + 5'd1;
                        end
                        else if (read_length_reg != 8'd0)
                        begin
                            // Repeated start into the read phase
                            res.send_start = 1'b1;
                            res.irq_enable = 1'b1;
                        end
                        else
                        begin
                            res.send_stop  = 1'b1;
                            res.completion = COMP_SUCCESS;
                        end
                    end
                    ST_SLA_R_ACK:
                    begin
                        res.control_valid = 1'b1;
                        res.irq_enable    = 1'b1;
                        res.ack_next      = !is_last_read(read_position_reg, read_length_reg);
                    end
                    ST_DATA_R_ACK:
                    begin
                        res.rx_valid      = 1'b1;
                        res.rx_byte       = byte_value;
                        res.rx_index      = read_position_reg;
                        rp_upd            = rp_inc;
                        res.control_valid = 1'b1;
                        res.irq_enable    = 1'b1;
                        res.ack_next      = !is_last_read(rp_inc, read_length_reg);
                    end
                    ST_DATA_R_NACK:
                    begin
                        // Final byte of the read: deliver, stop, success
                        res.rx_valid      = 1'b1;
                        res.rx_byte       = byte_value;
                        res.rx_index      = read_position_reg;
                        res.control_valid = 1'b1;
                        res.send_stop     = 1'b1;
                        res.completion    = COMP_SUCCESS;
                    end
                    ST_SLA_W_NACK, ST_DATA_W_NACK, ST_SLA_R_NACK:
                    begin
                        err_upd = error_store_reg | ERR_NACK;
                    end
                    ST_ARB_LOST:
                    begin
                        err_upd = error_store_reg | ERR_ARB_LOST;
                    end
                    ST_BUS_ERROR:
                    begin
                        err_upd = error_store_reg | ERR_BUS;
                    end
                    default:
                    begin
                        // Unknown code: stop with error, flags untouched
                        res.control_valid = 1'b1;
                        res.send_stop     = 1'b1;
                        res.completion    = COMP_ERROR;
                    end
                endcase

                // Any sticky error forces a bare stop; a received byte stays delivered
                if (err_upd != 3'd0)
                begin
                    res.control_valid  = 1'b1;
                    res.send_start     = 1'b0;
                    res.send_stop      = 1'b1;
                    res.ack_next       = 1'b0;
                    res.irq_enable     = 1'b0;
                    res.data_out_valid = 1'b0;
                    res.data_out       = '0;
                    res.completion     = COMP_ERROR;
                end
            end
            default:
            begin
                // Load or unused command: idle result
            end
        endcase

        res.error_flags = err_upd;
    end

    assign write_position_next = in_fire ? wp_upd  : write_position_reg;
    assign read_position_next  = in_fire ? rp_upd  : read_position_reg;
    assign error_store_next    = in_fire ? err_upd : error_store_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_position_reg <= '0;
            read_position_reg  <= '0;
            error_store_reg    <= '0;
            byp_hit_reg        <= 1'b0;
        end
        else
        begin
            write_position_reg <= write_position_next;
            read_position_reg  <= read_position_next;
            error_store_reg    <= error_store_next;
            byp_hit_reg        <= byp_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= byte_value;
    end

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            // skid is empty here, since in_ready requires it
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg  <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (out_fire && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign control_valid  = out_reg.control_valid;
    assign send_start     = out_reg.send_start;
    assign send_stop      = out_reg.send_stop;
    assign ack_next       = out_reg.ack_next;
    assign irq_enable     = out_reg.irq_enable;
    assign data_out_valid = out_reg.data_out_valid;
    assign data_out       = out_reg.data_out;
    assign rx_valid       = out_reg.rx_valid;
    assign rx_byte        = out_reg.rx_byte;
    assign rx_index       = out_reg.rx_index;
    assign completion     = out_reg.completion;
    assign error_flags    = out_reg.error_flags;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a result while the output register is empty");

    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !out_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("result into an empty output stage went to the skid stage");

    a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.control_valid && (out_reg.error_flags != 3'd0)) |->
        (out_reg.send_stop && !out_reg.send_start && !out_reg.irq_enable &&
         (out_reg.completion == COMP_ERROR)))
        else $error("sticky error without a forced stop");

    a_data_not_with_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.data_out_valid) |->
        (out_reg.control_valid && !out_reg.send_stop && !out_reg.send_start))
        else $error("data byte issued together with a bus condition");

endmodule

// File: bench/tb.sv
// Self-checking bench for the I2C master write-then-read transfer sequencer.
`timescale 1ns / 100ps

module tb
    import i2cmts_pkg::*;
();

    localparam int          STORE_DEPTH    = 16;
    localparam int          RESET_CYCLES   = 10;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          MAX_REPORTS    = 10;
    localparam int          DIRECTED_ROWS  = 25;
    localparam int          NUM_PHASES     = 9;
    localparam int          LONG_READ_PHASE = 4;
    localparam int          ITEMS_PER_PHASE = 50;
    // Command code 3 has no meaning; the block must answer it with an idle result
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;

    // One input item as it travels on the input channel
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] status;
        logic [7:0] data;
        logic [3:0] slot;
    } cmd_item_t;

    // Directed row: item plus, where obvious, the answer typed in by hand
    typedef struct packed {
        cmd_item_t item;
        logic      typed;
        result_t   want;
    } bench_row_t;

    localparam result_t RES_IDLE  = '0;
    localparam result_t RES_BEGIN = {1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00,
                                     1'b0, 8'h00, 8'h00, COMP_RUNNING, 3'b000};

    // Phase table: configuration and idling for each stretch of the run.
    // Phase 0 carries the directed rows, the long-read phase walks the read
    // position past 255, every other phase is random traffic.
    int phase_target    [NUM_PHASES] = '{127, 0, 85, 127, 42, 19, 127, 1, 108};
    int phase_wr_len    [NUM_PHASES] = '{2, 0, 16, 31, 1, 5, 3, 0, 8};
    int phase_rd_len    [NUM_PHASES] = '{2, 1, 3, 0, 255, 4, 1, 0, 2};
    int phase_send_idle [NUM_PHASES] = '{0, 75, 0, 10, 0, 75, 0, 10, 0};
    int phase_stall     [NUM_PHASES] = '{0, 0, 75, 10, 0, 0, 75, 10, 0};

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [7:0] status;
    logic [7:0] byte_value;
    logic [3:0] load_slot;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       control_valid;
    logic       send_start;
    logic       send_stop;
    logic       ack_next;
    logic       irq_enable;
    logic       data_out_valid;
    logic [7:0] data_out;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_index;
    logic [1:0] completion;
    logic [2:0] error_flags;

    // Shadow copy of the sequencer state and its configuration
    logic [7:0]             tx_store [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] tx_store_loaded;
    logic [4:0]             tx_pos;
    logic [7:0]             rx_pos;
    logic [2:0]             sticky_errors;
    logic [6:0]             cfg_target;
    logic [4:0]             cfg_wr_len;
    logic [7:0]             cfg_rd_len;

    // Bus actions predicted for accepted items, oldest first
    result_t    pending_results [$];
    result_t    observed;
    bench_row_t directed_rows [DIRECTED_ROWS];
    int         items_sent = 0;
    int         fail_count = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct = 0;
    int         stall_pct = 0;

    i2c_master_transfer_sequencer_unit #(
        .WRITE_DEPTH(STORE_DEPTH)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .status         (status),
        .byte_value     (byte_value),
        .load_slot      (load_slot),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .control_valid  (control_valid),
        .send_start     (send_start),
        .send_stop      (send_stop),
        .ack_next       (ack_next),
        .irq_enable     (irq_enable),
        .data_out_valid (data_out_valid),
        .data_out       (data_out),
        .rx_valid       (rx_valid),
        .rx_byte        (rx_byte),
        .rx_index       (rx_index),
        .completion     (completion),
        .error_flags    (error_flags)
    );

    always #1 clk = ~clk;

    // Stall the result channel at the rate the current phase asks for
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // Write lengths beyond the store depth are clipped to the store depth
    function automatic logic [4:0] tx_len_limit();
        return (cfg_wr_len > 5'(STORE_DEPTH)) ? 5'(STORE_DEPTH) : cfg_wr_len;
    endfunction

    // The byte about to arrive is the last of the read: NACK it
    function automatic logic last_read_pending();
        return (cfg_rd_len != 8'd0) && (({1'b0, rx_pos} + 9'd1) == {1'b0, cfg_rd_len});
    endfunction

    function automatic result_t stop_on_error(input logic [2:0] flags);
        return {1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00,
                COMP_ERROR, flags};
    endfunction

    // Advance the shadow state by one item and return the bus action it yields
    function automatic result_t next_bus_action(input cmd_item_t it);
        result_t    act;
        logic [7:0] code;
        logic [4:0] wlen;
        act  = '0;
        code = it.status & STATUS_MASK;
        wlen = tx_len_limit();
        case (it.cmd)
            CMD_LOAD:
            begin
                tx_store[it.slot]        = it.data;
                tx_store_loaded[it.slot] = 1'b1;
            end
            CMD_BEGIN:
            begin
                tx_pos             = '0;
                rx_pos             = '0;
                sticky_errors      = '0;
                act.control_valid  = 1'b1;
                act.send_start     = 1'b1;
                act.irq_enable     = 1'b1;
            end
            CMD_EVENT:
            begin
                case (code)
                    ST_START, ST_RSTART:
                    begin
                        // Read bit once there is nothing (left) to write
                        act.control_valid  = 1'b1;
                        act.irq_enable     = 1'b1;
                        act.data_out_valid = 1'b1;
                        act.data_out = {cfg_target,
                                        ((wlen == 5'd0) || (tx_pos == wlen)) ? READ_BIT : ~READ_BIT};
                    end
                    ST_SLA_W_ACK, ST_DATA_W_ACK:
                    begin
                        act.control_valid = 1'b1;
                        if (tx_pos < wlen)
                        begin
                            act.irq_enable     = 1'b1;
                            act.data_out_valid = 1'b1;
                            act.data_out       = tx_store[tx_pos[3:0]];
                            tx_pos             = tx_pos + 5'd1;
                        end
                        else if (cfg_rd_len != 8'd0)
                        begin
                            act.send_start = 1'b1;
                            act.irq_enable = 1'b1;
                        end
                        else
                        begin
                            act.send_stop  = 1'b1;
                            act.completion = COMP_SUCCESS;
                        end
                    end
                    ST_SLA_R_ACK:
                    begin
                        act.control_valid = 1'b1;
                        act.irq_enable    = 1'b1;
                        act.ack_next      = !last_read_pending();
                    end
                    ST_DATA_R_ACK:
                    begin
                        act.rx_valid      = 1'b1;
                        act.rx_byte       = it.data;
                        act.rx_index      = rx_pos;
                        rx_pos            = rx_pos + 8'd1;
                        act.control_valid = 1'b1;
                        act.irq_enable    = 1'b1;
                        act.ack_next      = !last_read_pending();
                    end
                    ST_DATA_R_NACK:
                    begin
                        act.rx_valid      = 1'b1;
                        act.rx_byte       = it.data;
                        act.rx_index      = rx_pos;
                        act.control_valid = 1'b1;
                        act.send_stop     = 1'b1;
                        act.completion    = COMP_SUCCESS;
                    end
                    ST_SLA_W_NACK, ST_DATA_W_NACK, ST_SLA_R_NACK:
                        sticky_errors = sticky_errors | ERR_NACK;
                    ST_ARB_LOST:
                        sticky_errors = sticky_errors | ERR_ARB_LOST;
                    ST_BUS_ERROR:
                        sticky_errors = sticky_errors | ERR_BUS;
                    default:
                    begin
                        act.control_valid = 1'b1;
                        act.send_stop     = 1'b1;
                        act.completion    = COMP_ERROR;
                    end
                endcase
                // Any sticky error turns the action into a bare stop; keep rx data
                if (sticky_errors != 3'b000)
                begin
                    act.control_valid  = 1'b1;
                    act.send_start     = 1'b0;
                    act.send_stop      = 1'b1;
                    act.ack_next       = 1'b0;
                    act.irq_enable     = 1'b0;
                    act.data_out_valid = 1'b0;
                    act.data_out       = 8'h00;
                    act.completion     = COMP_ERROR;
                end
            end
            default: ;
        endcase
        act.error_flags = sticky_errors;
        return act;
    endfunction

    function automatic cmd_item_t make_item(input logic [1:0] cmd, input logic [7:0] code);
        cmd_item_t it;
        it.cmd    = cmd;
        it.status = code | 8'($urandom_range(7));
        it.data   = 8'($urandom_range(255));
        it.slot   = 4'($urandom_range(15));
        return it;
    endfunction

    function automatic string show_result(input result_t r);
        return $sformatf({"cv%b start%b stop%b ack%b irq%b dv%b data%02h ",
                          "rxv%b rxb%02h rxi%02h comp%0d err%03b"},
                         r.control_valid, r.send_start, r.send_stop, r.ack_next,
                         r.irq_enable, r.data_out_valid, r.data_out, r.rx_valid,
                         r.rx_byte, r.rx_index, r.completion, r.error_flags);
    endfunction

    task automatic note_failure(input string what, input result_t want, input result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%0t: %s", $time, what);
            $display("    expected %s", show_result(want));
            $display("    actual   %s", show_result(got));
        end
    endtask

    // Present one item, hold it until its transfer, then queue its expected action.
    // Valid stays high across back-to-back items; drop it only for an idle gap.
    task automatic issue_command(input cmd_item_t it, input logic typed, input result_t want);
        result_t predicted;
        logic [7:0] code;
        code = it.status & STATUS_MASK;
        // Never let a write-data event fetch a store entry that was never loaded
        if (it.cmd == CMD_EVENT && (code == ST_SLA_W_ACK || code == ST_DATA_W_ACK) &&
            tx_pos < tx_len_limit() && !tx_store_loaded[tx_pos[3:0]])
            it.status = ST_DATA_R_ACK | (it.status & ~STATUS_MASK);
        predicted = next_bus_action(it);
        if (typed)
            predicted = want;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        command    <= it.cmd;
        status     <= it.status;
        byte_value <= it.data;
        load_slot  <= it.slot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(predicted);
        items_sent++;
    endtask

    // Random items of any command; used between and around well-formed transfers
    task automatic send_noise(input int count);
        repeat (count)
            issue_command(make_item(2'($urandom_range(3)), 8'($urandom_range(255))),
                          1'b0, RES_IDLE);
    endtask

    // Build a well-formed write-then-read sequence for the current configuration,
    // optionally break it with an error or unknown code, then send it
    task automatic run_transfer(input int extra_reads, input logic may_fault);
        cmd_item_t  steps [$];
        cmd_item_t  one;
        int         wlen;
        int         rlen;
        int         n_reads;
        int         first_event;
        int         fault_at;
        int         keep;
        int         k;
        logic [7:0] fault_code;
        wlen = int'(tx_len_limit());
        rlen = int'(cfg_rd_len);
        for (k = 0; k < wlen; k++)
            if (!tx_store_loaded[4'(k)] || $urandom_range(3) != 0)
            begin
                one      = make_item(CMD_LOAD, 8'h00);
                one.slot = 4'(k);
                steps.push_back(one);
            end
        steps.push_back(make_item(CMD_BEGIN, 8'h00));
        first_event = steps.size();
        steps.push_back(make_item(CMD_EVENT, ST_START));
        if (wlen != 0)
        begin
            steps.push_back(make_item(CMD_EVENT, ST_SLA_W_ACK));
            repeat (wlen)
                steps.push_back(make_item(CMD_EVENT, ST_DATA_W_ACK));
            if (rlen != 0)
                steps.push_back(make_item(CMD_EVENT, ST_RSTART));
        end
        if (rlen != 0 || wlen == 0)
        begin
            n_reads = (rlen == 0) ? extra_reads : rlen - 1 + extra_reads;
            steps.push_back(make_item(CMD_EVENT, ST_SLA_R_ACK));
            repeat (n_reads)
                steps.push_back(make_item(CMD_EVENT, ST_DATA_R_ACK));
            steps.push_back(make_item(CMD_EVENT, ST_DATA_R_NACK));
        end
        if (may_fault && $urandom_range(3) == 0)
        begin
            fault_at = $urandom_range(steps.size() - 1, first_event);
            case ($urandom_range(5))
                0:       fault_code = ST_SLA_W_NACK;
                1:       fault_code = ST_DATA_W_NACK;
                2:       fault_code = ST_SLA_R_NACK;
                3:       fault_code = ST_ARB_LOST;
                4:       fault_code = ST_BUS_ERROR;
                default: fault_code = 8'($urandom_range(31, 12) << 3);
            endcase
            one        = steps[fault_at];
            one.status = fault_code | (one.status & ~STATUS_MASK);
            steps[fault_at] = one;
            // Let up to two events run on after the fault, drop the rest
            keep = fault_at + 1 + $urandom_range(2);
            while (steps.size() > keep)
                steps.delete(steps.size() - 1);
        end
        for (k = 0; k < steps.size(); k++)
            issue_command(steps[k], 1'b0, RES_IDLE);
    endtask

    // Write one register; leave valid high so the next write can follow at once
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_TARGET_ADDRESS: cfg_target = value[6:0];
            CFG_WRITE_LENGTH:   cfg_wr_len = value[4:0];
            CFG_READ_LENGTH:    cfg_rd_len = value;
            default: ;
        endcase
    endtask

    // Compare every result transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            observed = {control_valid, send_start, send_stop, ack_next, irq_enable,
                        data_out_valid, data_out, rx_valid, rx_byte, rx_index,
                        completion, error_flags};
            if (pending_results.size() == 0)
            begin
                note_failure("result with nothing pending", '0, observed);
            end
            else
            begin
                if (observed !== pending_results[0])
                    note_failure("result mismatch", pending_results[0], observed);
                pending_results.delete(0);
            end
        end
    end

    // Watchdog: end the run when no transfer happens on any channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("i2c_master_transfer_sequencer_unit test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int p;
        int r;
        int stop_at;

        // Drive every input to a known value and hold reset
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = CFG_TARGET_ADDRESS;
        cfg_data        = 8'h00;
        in_valid        = 1'b0;
        command         = CMD_LOAD;
        status          = 8'h00;
        byte_value      = 8'h00;
        load_slot       = 4'h0;
        tx_store_loaded = '0;
        tx_pos          = '0;
        rx_pos          = '0;
        sticky_errors   = '0;
        cfg_target      = '0;
        cfg_wr_len      = '0;
        cfg_rd_len      = '0;

        // Directed rows, run with address 127, two bytes written, two read.
        // Typed answers: idle results, begin, and the error stops.
        directed_rows = '{
            // unused command with every field at its maximum
            {CMD_UNUSED, 8'hFF, 8'hFF, 4'hF, 1'b1, RES_IDLE},
            // load the store, lowest and highest slot included
            {CMD_LOAD,   8'h00, 8'hFF, 4'h0, 1'b1, RES_IDLE},
            {CMD_LOAD,   8'hFF, 8'h00, 4'h1, 1'b1, RES_IDLE},
            {CMD_LOAD,   8'h00, 8'h5A, 4'hF, 1'b1, RES_IDLE},
            // complete write-then-read: address, two bytes, repeated start,
            // read address, two bytes with the last one NACKed
            {CMD_BEGIN,  8'h00, 8'h00, 4'h0, 1'b1, RES_BEGIN},
            {CMD_EVENT,  8'h0F, 8'h00, 4'hF, 1'b0, RES_IDLE},
            {CMD_EVENT,  8'h18, 8'h00, 4'h0, 1'b0, RES_IDLE},
            {CMD_EVENT,  8'h2F, 8'hFF, 4'h0, 1'b0, RES_IDLE},
            {CMD_EVENT,  8'h28, 8'h00, 4'h0, 1'b0, RES_IDLE},
            {CMD_EVENT,  8'h10, 8'h00, 4'h0, 1'b0, RES_IDLE},
            {CMD_EVENT,  8'h40, 8'h00, 4'h0, 1'b0, RES_IDLE},
            {CMD_EVENT,  8'h50, 8'hFF, 4'h0, 1'b0, RES_IDLE},
            {CMD_EVENT,  8'h5F, 8'h00, 4'hF, 1'b0, RES_IDLE},
            // sticky errors pile up until the next begin
            {CMD_BEGIN,  8'hFF, 8'hFF, 4'hF, 1'b1, RES_BEGIN},
            {CMD_EVENT,  8'h20, 8'h00, 4'h0, 1'b1, stop_on_error(ERR_NACK)},
            {CMD_EVENT,  8'h3F, 8'h00, 4'h0, 1'b1, stop_on_error(ERR_NACK | ERR_ARB_LOST)},
            {CMD_EVENT,  8'h07, 8'h00, 4'h0, 1'b1,
             stop_on_error(ERR_NACK | ERR_ARB_LOST | ERR_BUS)},
            {CMD_BEGIN,  8'h00, 8'h00, 4'h0, 1'b1, RES_BEGIN},
            {CMD_EVENT,  8'h30, 8'h00, 4'h0, 1'b1, stop_on_error(ERR_NACK)},
            {CMD_BEGIN,  8'h00, 8'h00, 4'h0, 1'b1, RES_BEGIN},
            {CMD_EVENT,  8'h48, 8'h00, 4'h0, 1'b1, stop_on_error(ERR_NACK)},
            // unknown codes (a slave code, then all ones) stop without a flag
            {CMD_BEGIN,  8'h00, 8'h00, 4'h0, 1'b1, RES_BEGIN},
            {CMD_EVENT,  8'h60, 8'h00, 4'h0, 1'b1, stop_on_error(3'b000)},
            {CMD_EVENT,  8'hFF, 8'hFF, 4'hF, 1'b1, stop_on_error(3'b000)},
            {CMD_UNUSED, 8'h00, 8'h00, 4'h0, 1'b1, RES_IDLE}
        };

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // Drain: drop valid and let every pending result arrive before
            // touching the registers
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (2)
                @(posedge clk);
            send_idle_pct = phase_send_idle[p];
            stall_pct     = phase_stall[p];
            write_reg(CFG_TARGET_ADDRESS, 8'(phase_target[p]));
            write_reg(CFG_WRITE_LENGTH, 8'(phase_wr_len[p]));
            write_reg(CFG_READ_LENGTH, 8'(phase_rd_len[p]));
            cfg_valid <= 1'b0;

            if (p == 0)
            begin
                for (r = 0; r < DIRECTED_ROWS; r++)
                    issue_command(directed_rows[r].item, directed_rows[r].typed,
                                  directed_rows[r].want);
            end
            else if (p == LONG_READ_PHASE)
            begin
                // Read past the last byte so that the read position wraps through zero
                run_transfer(3, 1'b0);
                send_noise(12);
            end
            else
            begin
                // Mostly well-formed transfers, with bursts of random items between
                stop_at = items_sent + ITEMS_PER_PHASE;
                while (items_sent < stop_at)
                    if ($urandom_range(4) == 0)
                        send_noise($urandom_range(4, 1));
                    else
                        run_transfer(0, 1'b1);
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        if (fail_count == 0)
            $display("i2c_master_transfer_sequencer_unit test passed");
        else
            $display("i2c_master_transfer_sequencer_unit test failed");
        $finish;
    end

endmodule
